### rtl/core/usp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// URL splitter package
// Shared types and constants of the URL host, port and path splitter.
// ----------------------------------------------------------------------------
package usp_pkg;

  localparam int unsigned HostDepthDefault  = 32;
  localparam logic [15:0] DefaultPortReset = 16'd80;

  localparam logic [7:0] ChAt     = 8'h40;
  localparam logic [7:0] ChColon  = 8'h3a;
  localparam logic [7:0] ChClose  = 8'h5d;
  localparam logic [7:0] ChOpen   = 8'h5b;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  typedef enum logic [1:0] {
    KIND_PATH = 2'd0,
    KIND_HOST = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] url_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    kind_e              item_kind;
    logic [7:0]         text_byte;
    logic signed [31:0] port_number;
    logic               status_code;
    logic               run_end;
  } out_item_t;

  typedef struct packed {
    logic       is_path;
    logic [7:0] ch;
    logic       fin;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/core/url_host_port_path_splitter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// URL host, port and path splitter
// Splits a URL byte stream into path bytes, host bytes and an end record.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle into a two-entry command queue while it is not
// full; path bytes are passed to the output register as they arrive. On the
// final byte the resolver scans the host buffer through its single read port,
// parses the port from the characters after the colon and emits the host bytes;
// while it does so it takes no commands, so the queue fills and full is raised.
module url_host_port_path_splitter_top import usp_pkg::*; #(
  parameter int unsigned HostDepth = HostDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_item_i,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        out_item_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  logic q_push, q_full, q_pop, q_valid;
  cmd_t q_wcmd, q_rcmd;

  assign full = q_full;

  usp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .in_item_i(in_item_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_wcmd)
  );

  usp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wcmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rdata_o(q_rcmd),
    .valid_o(q_valid)
  );

  usp_back #(.HostDepth(HostDepth)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_rcmd),
    .cmd_pop_o  (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule
`default_nettype wire

### rtl/core/usp_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue between the classifier and the resolver.
// ----------------------------------------------------------------------------
module usp_fifo import usp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t wdata_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      rdata_o,
  output logic      valid_o
);

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

### rtl/core/usp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Byte classifier
// Marks each incoming byte as host or path and forwards it as a command.
// ----------------------------------------------------------------------------
module usp_front import usp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire in_item_t in_item_i,
  input  wire logic     q_full_i,
  output logic          q_push_o,
  output cmd_t          q_cmd_o
);

  logic path_started_q;

  assign q_push_o        = push_i && !q_full_i;
  assign q_cmd_o.is_path = path_started_q || (in_item_i.url_byte == ChSlash);
  assign q_cmd_o.ch      = in_item_i.url_byte;
  assign q_cmd_o.fin     = in_item_i.final_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_started_q <= 1'b0;
    end else if (q_push_o) begin
      path_started_q <= in_item_i.final_byte ? 1'b0 : q_cmd_o.is_path;
    end
  end

endmodule
`default_nettype wire

### rtl/core/usp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Host resolver
// Buffers host bytes, emits path bytes and resolves host and port at the end.
// ----------------------------------------------------------------------------
module usp_back import usp_pkg::*; #(
  parameter int unsigned HostDepth = HostDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        cmd_valid_i,
  input  wire cmd_t        cmd_i,
  output logic             cmd_pop_o,
  output logic             empty_o,
  input  wire logic        pop_i,
  output out_item_t        out_item_o
);

  localparam int unsigned CW = $clog2(HostDepth + 1);
  localparam int unsigned AW = $clog2(HostDepth);
  localparam logic [CW-1:0] DepthC = CW'(HostDepth);
  localparam logic [31:0] MagMax = 32'h8000_0000;
  localparam logic [31:0] PosMax = 32'h7fff_ffff;

  typedef enum logic [2:0] {
    S_IDLE, S_SLASH, S_SCAN, S_DECIDE, S_PORT, S_FIX, S_EMIT, S_END
  } state_e;

  typedef enum logic [1:0] {
    P_BLANK, P_DIGIT
  } pstage_e;

  logic [7:0]    mem_q [HostDepth];
  logic [7:0]    rdata_q;
  state_e        state_q;
  pstage_e       pst_q;
  logic          ph_q;
  logic [CW-1:0] cnt_q, idx_q, start_q, end_q, col_q;
  logic          ovf_q, at_q, hcol_q, closer_q, hrb_q, lbr_q;
  logic          neg_q, any_q;
  logic [31:0]   mag_q;
  logic [31:0]   port_q;
  logic [15:0]   dport_q;
  out_item_t     out_q;
  logic          oval_q;

  logic          can_out;
  logic          out_set;
  logic          wr_en;
  logic          is_blank, is_digit;
  logic [35:0]   mag_ext;
  logic [31:0]   mag_nx;
  logic [31:0]   raw_port;

  assign can_out   = !oval_q || pop_i;
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i && (!cmd_i.is_path || can_out);
  assign wr_en     = cmd_pop_o && !cmd_i.is_path && (cnt_q < DepthC);
  assign empty_o   = !oval_q;
  assign out_item_o = out_q;
  assign out_set   = ((state_q == S_IDLE) && cmd_pop_o && cmd_i.is_path)
                     || ((state_q == S_SLASH) && can_out)
                     || ((state_q == S_EMIT) && ph_q && can_out)
                     || ((state_q == S_END) && can_out);

  assign is_blank = (rdata_q == ChSpace) || ((rdata_q >= ChTab) && (rdata_q <= ChCr));
  assign is_digit = (rdata_q >= ChZero) && (rdata_q <= ChNine);
  assign mag_ext  = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1)
                    + {32'd0, rdata_q[3:0]};
  assign mag_nx   = (mag_ext > {4'd0, MagMax}) ? MagMax : mag_ext[31:0];

  always_comb begin
    if (!any_q) begin
      raw_port = 32'd0;
    end else if (neg_q) begin
      raw_port = 32'd0 - mag_q;
    end else begin
      raw_port = (mag_q > PosMax) ? PosMax : mag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[AW-1:0]] <= cmd_i.ch;
    end
    rdata_q <= mem_q[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pst_q    <= P_BLANK;
      ph_q     <= 1'b0;
      cnt_q    <= '0;
      idx_q    <= '0;
      start_q  <= '0;
      end_q    <= '0;
      col_q    <= '0;
      ovf_q    <= 1'b0;
      at_q     <= 1'b0;
      hcol_q   <= 1'b0;
      closer_q <= 1'b0;
      hrb_q    <= 1'b0;
      lbr_q    <= 1'b0;
      neg_q    <= 1'b0;
      any_q    <= 1'b0;
      mag_q    <= '0;
      port_q   <= '0;
      dport_q  <= DefaultPortReset;
      out_q    <= '0;
      oval_q   <= 1'b0;
    end else begin
      if (cfg_we_i) dport_q <= cfg_wdata_i;
      if (out_set) begin
        oval_q <= 1'b1;
      end else if (pop_i) begin
        oval_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_pop_o) begin
            if (cmd_i.is_path) begin
              out_q  <= '{KIND_PATH, cmd_i.ch, 32'sd0, 1'b0, 1'b0};
            end else if (cnt_q < DepthC) begin
              cnt_q <= cnt_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (cmd_i.fin) begin
              idx_q    <= '0;
              ph_q     <= 1'b0;
              start_q  <= '0;
              at_q     <= 1'b0;
              hcol_q   <= 1'b0;
              closer_q <= 1'b0;
              hrb_q    <= 1'b0;
              lbr_q    <= 1'b0;
              state_q  <= cmd_i.is_path ? S_SCAN : S_SLASH;
            end
          end
        end
        S_SLASH: begin
          if (can_out) begin
            out_q   <= '{KIND_PATH, ChSlash, 32'sd0, 1'b0, 1'b0};
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!ph_q) begin
            if (idx_q == cnt_q) begin
              state_q <= S_DECIDE;
            end else begin
              ph_q <= 1'b1;
            end
          end else begin
            ph_q  <= 1'b0;
            idx_q <= idx_q + 1'b1;
            if (rdata_q == ChAt && !at_q) begin
              at_q     <= 1'b1;
              start_q  <= idx_q + 1'b1;
              hcol_q   <= 1'b0;
              closer_q <= 1'b0;
              hrb_q    <= 1'b0;
              lbr_q    <= 1'b0;
            end else begin
              if (idx_q == start_q && rdata_q == ChOpen) lbr_q <= 1'b1;
              if (rdata_q == ChColon) begin
                hcol_q   <= 1'b1;
                col_q    <= idx_q;
                closer_q <= 1'b0;
              end
              if (rdata_q == ChClose) begin
                closer_q <= 1'b1;
                hrb_q    <= 1'b1;
              end
            end
          end
        end
        S_DECIDE: begin
          neg_q <= 1'b0;
          any_q <= 1'b0;
          mag_q <= '0;
          pst_q <= P_BLANK;
          ph_q  <= 1'b0;
          if (hcol_q && !closer_q) begin
            end_q   <= col_q;
            idx_q   <= col_q + 1'b1;
            state_q <= S_PORT;
          end else begin
            end_q   <= cnt_q;
            state_q <= S_FIX;
          end
        end
        S_PORT: begin
          if (!ph_q) begin
            if (idx_q == cnt_q) begin
              state_q <= S_FIX;
            end else begin
              ph_q <= 1'b1;
            end
          end else begin
            ph_q  <= 1'b0;
            idx_q <= idx_q + 1'b1;
            if (is_digit) begin
              any_q <= 1'b1;
              mag_q <= mag_nx;
              pst_q <= P_DIGIT;
            end else if (pst_q == P_BLANK && is_blank) begin
              pst_q <= P_BLANK;
            end else if (pst_q == P_BLANK && (rdata_q == ChPlus || rdata_q == ChMinus)) begin
              neg_q <= rdata_q == ChMinus;
              pst_q <= P_DIGIT;
            end else begin
              state_q <= S_FIX;
            end
          end
        end
        S_FIX: begin
          port_q <= (raw_port == 32'd0) ? {16'd0, dport_q} : raw_port;
          ph_q   <= 1'b0;
          if (end_q > start_q && lbr_q && hrb_q) begin
            idx_q <= start_q + 1'b1;
            end_q <= end_q - 1'b1;
          end else begin
            idx_q <= start_q;
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!ph_q) begin
            if (idx_q >= end_q) begin
              state_q <= S_END;
            end else begin
              ph_q <= 1'b1;
            end
          end else if (can_out) begin
            out_q  <= '{KIND_HOST, rdata_q, 32'sd0, 1'b0, 1'b0};
            idx_q  <= idx_q + 1'b1;
            ph_q   <= 1'b0;
          end
        end
        S_END: begin
          if (can_out) begin
            out_q   <= '{KIND_END, 8'd0, $signed(port_q), ovf_q, 1'b1};
            cnt_q   <= '0;
            ovf_q   <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// URL splitter testbench
// Drives URL byte streams into the splitter with random idling on both sides
// and compares every result transfer with a predicted queue of results.
// ----------------------------------------------------------------------------
module tb_top;
  import usp_pkg::*;

  localparam int unsigned Depth = HostDepthDefault;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  url_host_port_path_splitter_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .in_item_i(in_item_i),
    .empty(empty), .pop(pop), .out_item_o(out_item_o), .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [7:0]  host_buf [Depth];
  int unsigned host_len;
  bit          in_path;
  bit          host_lost;
  logic [15:0] port_default;
  out_item_t   expected_q [$];
  int          fail_count;
  bit          calm;
  int          byte_count;

  function automatic bit is_blank(logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic [31:0] parse_port(int unsigned from, int unsigned upto);
    int unsigned i;
    bit          neg;
    bit          any;
    longint unsigned mag;
    i = from;
    neg = 0;
    any = 0;
    mag = 0;
    while (i < upto && is_blank(host_buf[i])) i++;
    if (i < upto && (host_buf[i] == ChPlus || host_buf[i] == ChMinus)) begin
      neg = host_buf[i] == ChMinus;
      i++;
    end
    while (i < upto && host_buf[i] >= ChZero && host_buf[i] <= ChNine) begin
      any = 1;
      mag = mag * 10 + (host_buf[i] - ChZero);
      if (mag > 64'd2147483648) mag = 64'd2147483648;
      i++;
    end
    if (!any) return '0;
    if (neg) return 32'd0 - mag[31:0];
    if (mag > 64'd2147483647) mag = 64'd2147483647;
    return mag[31:0];
  endfunction

  function automatic out_item_t make_result(kind_e k, logic [7:0] c, logic [31:0] p,
                                            logic st, logic last);
    out_item_t r;
    r.item_kind = k;
    r.text_byte = c;
    r.port_number = p;
    r.status_code = st;
    r.run_end = last;
    return r;
  endfunction

  task automatic predict_split(in_item_t it);
    int unsigned first, stop, colon, i;
    bit          has_colon, closer;
    logic [31:0] port;
    if (!in_path && it.url_byte != ChSlash) begin
      if (host_len < Depth) begin
        host_buf[host_len] = it.url_byte;
        host_len++;
      end else begin
        host_lost = 1;
      end
    end else begin
      in_path = 1;
      expected_q.push_back(make_result(KIND_PATH, it.url_byte, '0, 1'b0, 1'b0));
    end
    if (!it.final_byte) return;
    if (!in_path) expected_q.push_back(make_result(KIND_PATH, ChSlash, '0, 1'b0, 1'b0));
    first = 0;
    stop = host_len;
    port = '0;
    has_colon = 0;
    colon = 0;
    for (i = 0; i < stop; i++) begin
      if (host_buf[i] == ChAt) begin
        first = i + 1;
        break;
      end
    end
    for (i = first; i < stop; i++) begin
      if (host_buf[i] == ChColon) begin
        has_colon = 1;
        colon = i;
      end
    end
    if (has_colon) begin
      closer = 0;
      for (i = colon + 1; i < stop; i++) if (host_buf[i] == ChClose) closer = 1;
      if (!closer) begin
        port = parse_port(colon + 1, stop);
        stop = colon;
      end
    end
    if (port == 0) port = {16'd0, port_default};
    if (stop > first && host_buf[first] == ChOpen) begin
      closer = 0;
      for (i = first; i < stop; i++) if (host_buf[i] == ChClose) closer = 1;
      if (closer) begin
        first++;
        stop--;
      end
    end
    for (i = first; i < stop; i++) begin
      expected_q.push_back(make_result(KIND_HOST, host_buf[i], '0, 1'b0, 1'b0));
    end
    expected_q.push_back(make_result(KIND_END, 8'd0, port, host_lost, 1'b1));
    host_len = 0;
    in_path = 0;
    host_lost = 0;
  endtask

  task automatic send_byte(logic [7:0] b, logic fin);
    while (!calm && $urandom_range(99) < 14) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= '{url_byte: b, final_byte: fin};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_split('{url_byte: b, final_byte: fin});
    byte_count++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic drain_and_set(logic [15:0] p);
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (6 * Depth + 20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= p;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    port_default = p;
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (pop && !empty) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_item_o.item_kind != want.item_kind) begin
          $error("item_kind exp %0d got %0d", want.item_kind, out_item_o.item_kind);
          fail_count++;
        end
        if (out_item_o.text_byte != want.text_byte) begin
          $error("text_byte exp %h got %h", want.text_byte, out_item_o.text_byte);
          fail_count++;
        end
        if (out_item_o.port_number != want.port_number) begin
          $error("port_number exp %0d got %0d", want.port_number, out_item_o.port_number);
          fail_count++;
        end
        if (out_item_o.status_code != want.status_code) begin
          $error("status_code exp %0d got %0d", want.status_code, out_item_o.status_code);
          fail_count++;
        end
        if (out_item_o.run_end != want.run_end) begin
          $error("run_end exp %0d got %0d", want.run_end, out_item_o.run_end);
          fail_count++;
        end
      end
    end
    pop <= calm || ($urandom_range(99) >= 14);
  end

  string directed_tbl [] = '{
    "a", "/", "host", "example.com/idx", "u:p@h:8080/x", "h:0", "h:-5", "h:99999999999",
    "h: +42", "h:-99999999999", "[::1]:443/", "[::1]", "h:abc", "a@b@c:7",
    "abcdefghijklmnopqrstuvwxyz0123456789XYZ/q", "h:"
  };

  string alphabet = "abc09:@[]/+- .";

  initial begin
    int n;
    host_len = 0;
    in_path = 0;
    host_lost = 0;
    port_default = DefaultPortReset;
    fail_count = 0;
    calm = 0;
    byte_count = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_tbl[i]) send_text(directed_tbl[i]);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    drain_and_set(16'd0);
    send_text("h:0/");
    drain_and_set(16'hffff);
    send_text("h");
    drain_and_set(16'd8443);
    while (byte_count < 300) begin
      calm = (byte_count > 200 && byte_count < 260);
      n = $urandom_range(3) == 0 ? $urandom_range(40) : $urandom_range(10);
      for (int i = 0; i <= n; i++) begin
        if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)), i == n);
        else send_byte(alphabet[$urandom_range(alphabet.len() - 1)], i == n);
      end
      if ($urandom_range(30) == 0) drain_and_set(16'($urandom_range(65535)));
    end
    calm = 0;
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (6 * Depth + 20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[url_host_port_path_splitter_top] OK");
    end else begin
      $display("[url_host_port_path_splitter_top] ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[url_host_port_path_splitter_top] ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/core/usp_pkg.sv
rtl/core/usp_fifo.sv
rtl/core/usp_front.sv
rtl/core/usp_back.sv
rtl/core/url_host_port_path_splitter_top.sv
dv/tb_top.sv
